// ===== src/spq_pkg.sv =====
// spq_pkg: shared types and constants for the stable priority queue.
// Used by spq_cell and stable_priority_queue; depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int PRIO_W       = 4;
  localparam int ID_W         = 31;
  localparam int OCC_W        = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/stable_priority_queue.sv =====
// Stable priority queue: result strobed on out_valid the cycle after accept.
// Throughput: one transaction per clock; busy is never raised, every cell shifts in parallel.
// The receiver cannot stall; each result is presented for exactly one cycle.
// Reset (synchronous, rst_n low) empties the queue and drops any pending strobe.
// Slot contents are not reset; only slots below the entry count are ever read.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire                         in_cmd,
  input  wire [spq_pkg::PRIO_W-1:0]   in_priority_req,
  input  wire [spq_pkg::ID_W-1:0]     in_entry_id,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority,
  output logic [spq_pkg::ID_W-1:0]    out_id,
  output logic [spq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // ---------------------------------------------------------------
  // Command decode. The chain settles a whole insert or remove
  // combinationally, so a new transaction is accepted on every clock.
  // ---------------------------------------------------------------
  logic                acc;
  logic                is_rem;
  logic                full;
  logic                empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;

  assign busy      = 1'b0;
  assign acc       = start && !busy;
  assign is_rem    = (in_cmd == spq_pkg::CMD_REMOVE);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign ctrl.ins  = acc && !is_rem && !full;
  assign ctrl.rem  = acc && is_rem && !empty;
  assign new_entry = '{prio: in_priority_req, id: in_entry_id};

  // ---------------------------------------------------------------
  // Cell chain. Slot 0 is the head. Each cell raises take when it sits
  // at or behind the insert point; because the row is sorted, take is
  // monotonic along the chain, so the first taking cell loads the new
  // entry and every later taking cell loads its left neighbor. Ties go
  // behind existing entries, which keeps equal priorities in arrival
  // order. A remove shifts every cell one step toward the head.
  // ---------------------------------------------------------------
  logic            take_w     [CAPACITY];
  spq_pkg::entry_t data_w     [CAPACITY];
  logic            occupied_w [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            lt;
    spq_pkg::entry_t le;
    spq_pkg::entry_t re;

    assign occupied_w[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign lt = 1'b0;
      assign le = new_entry;
    end else begin : g_mid
      assign lt = take_w[i-1];
      assign le = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign re = data_w[i];
    end else begin : g_body
      assign re = data_w[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied_w[i]),
      .new_entry   (new_entry),
      .left_take   (lt),
      .left_entry  (le),
      .right_entry (re),
      .take        (take_w[i]),
      .entry       (data_w[i])
    );
  end

  // ---------------------------------------------------------------
  // Entry count
  // ---------------------------------------------------------------
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register: status, popped head (zero unless removed) and
  // occupancy after the transaction, strobed for one cycle.
  // ---------------------------------------------------------------
  logic                        out_valid_r;
  spq_pkg::status_t            status_nxt;
  spq_pkg::status_t            out_status_r;
  logic [spq_pkg::PRIO_W-1:0]  out_priority_r;
  logic [spq_pkg::PRIO_W-1:0]  out_priority_nxt;
  logic [spq_pkg::ID_W-1:0]    out_id_r;
  logic [spq_pkg::ID_W-1:0]    out_id_nxt;
  logic [spq_pkg::OCC_W-1:0]   out_occ_r;

  always_comb begin
    status_nxt       = spq_pkg::ST_INSERTED;
    out_priority_nxt = '0;
    out_id_nxt       = '0;
    if (is_rem) begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        status_nxt       = spq_pkg::ST_REMOVED;
        out_priority_nxt = data_w[0].prio;
        out_id_nxt       = data_w[0].id;
      end
    end else if (full) begin
      status_nxt = spq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r   <= status_nxt;
      out_priority_r <= out_priority_nxt;
      out_id_r       <= out_id_nxt;
      out_occ_r      <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_priority  = out_priority_r;
  assign out_id        = out_id_r;
  assign out_occupancy = out_occ_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted transaction gave no result strobe");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not decrement the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    occupied_w[CAPACITY-1] |-> data_w[0].prio <= data_w[CAPACITY-1].prio)
    else $error("full queue head less urgent than tail");

endmodule

`default_nettype wire

// ===== src/spq_cell.sv =====
// spq_cell: one slot of the sorted shift-register queue.
// Depends on spq_pkg (entry_t, cell_ctrl_t).
`default_nettype none

module spq_cell (
  input  wire                 clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  wire                 occupied,
  input  spq_pkg::entry_t     new_entry,
  input  wire                 left_take,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output logic                take,
  output spq_pkg::entry_t     entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // slot is at or behind the insert point: empty, or strictly less urgent
  assign take  = !occupied || (entry_r.prio > new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && take) begin
      entry_nxt = left_take ? left_entry : new_entry;
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== test/stable_priority_queue_test.sv =====
// Self-checking testbench for stable_priority_queue: directed and random insert/remove traffic.
// A sorted shadow copy of the queue predicts every result; depends on spq_pkg and the RTL.
`default_nettype none

module stable_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = spq_pkg::CAPACITY_DEF;
  // Worst case is about 1700 transactions plus idle gaps; this is far above it.
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 100;
  localparam logic [spq_pkg::ID_W-1:0] ID_MAX = '1;

  // One expected result transaction.
  typedef struct {
    spq_pkg::status_t           status;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::ID_W-1:0]   id;
    logic [spq_pkg::OCC_W-1:0]  occ;
  } reply_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_cmd;
  logic [spq_pkg::PRIO_W-1:0]   in_priority_req;
  logic [spq_pkg::ID_W-1:0]     in_entry_id;
  logic                         out_valid;
  logic [1:0]                   out_status;
  logic [spq_pkg::PRIO_W-1:0]   out_priority;
  logic [spq_pkg::ID_W-1:0]     out_id;
  logic [spq_pkg::OCC_W-1:0]    out_occupancy;

  // Shadow of the queue contents, kept sorted head first.
  spq_pkg::entry_t shadow_slots [QUEUE_DEPTH];
  int              shadow_count;

  reply_t expected_replies [$];
  int     mismatch_count;
  int     cycle_count;

  stable_priority_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_priority_req(in_priority_req),
    .in_entry_id    (in_entry_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_priority   (out_priority),
    .out_id         (out_id),
    .out_occupancy  (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the shadow queue and returns the result it should produce.
  // Inserts go behind every entry of equal or smaller priority, so ties stay in FIFO order.
  function automatic reply_t apply_command(input spq_pkg::cmd_t cmd,
                                           input logic [spq_pkg::PRIO_W-1:0] prio,
                                           input logic [spq_pkg::ID_W-1:0] id);
    reply_t r;
    int     pos;
    r.status = spq_pkg::ST_INSERTED;
    r.prio   = '0;
    r.id     = '0;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_slots[pos].prio <= prio) pos++;
        for (int k = shadow_count; k > pos; k--) shadow_slots[k] = shadow_slots[k-1];
        shadow_slots[pos].prio = prio;
        shadow_slots[pos].id   = id;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.status = spq_pkg::ST_REMOVED;
        r.prio   = shadow_slots[0].prio;
        r.id     = shadow_slots[0].id;
        for (int k = 1; k < shadow_count; k++) shadow_slots[k-1] = shadow_slots[k];
        shadow_count--;
      end
    end
    r.occ = spq_pkg::OCC_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] ERROR %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Drives one transaction and holds it until the block takes it.
  // Returns on the accepting edge without touching start, so a following
  // transaction simply overwrites the fields.
  task automatic issue_command(input spq_pkg::cmd_t cmd,
                               input logic [spq_pkg::PRIO_W-1:0] prio,
                               input logic [spq_pkg::ID_W-1:0] id);
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_priority_req <= prio;
    in_entry_id     <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_replies.push_back(apply_command(cmd, prio, id));
  endtask

  // Idle gap; junk on the payload ports must be ignored while start is low.
  task automatic idle_cycles(input int n);
    start           <= 1'b0;
    in_cmd          <= 1'($urandom_range(0, 1));
    in_priority_req <= spq_pkg::PRIO_W'($urandom_range(0, 15));
    in_entry_id     <= spq_pkg::ID_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Holds off the sender until every pending result has come back.
  // Always waits on the clock before checking, so start is not re-driven in the same step.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // Result check: out_valid is a one-cycle strobe, sampled at the edge that ends it.
  always @(posedge clk) begin : check_results
    reply_t want;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result with no command pending: status %0d id %0h",
                                  out_status, out_id));
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
        if (out_priority !== want.prio)
          report_mismatch($sformatf("priority got %0d expected %0d", out_priority, want.prio));
        if (out_id !== want.id)
          report_mismatch($sformatf("id got %0h expected %0h", out_id, want.id));
        if (out_occupancy !== want.occ)
          report_mismatch($sformatf("occupancy got %0d expected %0d", out_occupancy, want.occ));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Remove on an empty queue: status empty, zero payload, nothing changes.
  // Payload fields are at opposite extremes to show they are ignored.
  task automatic test_empty_remove();
    issue_command(spq_pkg::CMD_REMOVE, 4'hF, ID_MAX);
    issue_command(spq_pkg::CMD_REMOVE, 4'h0, '0);
  endtask

  // Fill to capacity with ties at 0, 7 and 15 and extreme ids, then overflow twice.
  task automatic test_fill_and_overflow();
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::ID_W-1:0]   id;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio = i[0] ? 4'd0 : (i[1] ? 4'd15 : 4'd7);
      id   = (i == 0) ? ID_MAX : (i == 1) ? '0 : spq_pkg::ID_W'(32'h1234_5000 + i);
      issue_command(spq_pkg::CMD_INSERT, prio, id);
    end
    // queue full: both of these are dropped
    issue_command(spq_pkg::CMD_INSERT, 4'd0, ID_MAX);
    issue_command(spq_pkg::CMD_INSERT, 4'd15, '0);
  endtask

  // Pull several heads: the priority-0 ties must come out in arrival order.
  task automatic test_stable_order();
    repeat (6) issue_command(spq_pkg::CMD_REMOVE, spq_pkg::PRIO_W'($urandom_range(0, 15)),
                             spq_pkg::ID_W'($urandom));
  endtask

  // Random traffic in segments with different insert ratios so occupancy swings
  // between empty and full. Priorities are often from a narrow window to force ties.
  task automatic test_random_traffic(input int n_items);
    int                         sent;
    int                         seg_left;
    int                         insert_pct;
    int                         burst_left;
    bit                         narrow;
    logic [spq_pkg::PRIO_W-1:0] prio_base;
    logic [spq_pkg::PRIO_W-1:0] prio;
    spq_pkg::cmd_t              cmd;
    sent       = 0;
    seg_left   = 0;
    burst_left = 0;
    insert_pct = 50;
    narrow     = 1'b0;
    prio_base  = '0;
    while (sent < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        case ($urandom_range(0, 4))
          0: insert_pct = 15;
          1: insert_pct = 40;
          2: insert_pct = 50;
          3: insert_pct = 60;
          default: insert_pct = 85;
        endcase
        narrow    = ($urandom_range(0, 1) == 1);
        prio_base = spq_pkg::PRIO_W'($urandom_range(0, 14));
      end
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 6));
        // now and then a long stretch with no gaps at all
        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
      end
      if (sent == n_items / 2) wait_drained();
      cmd  = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE;
      prio = narrow ? prio_base + spq_pkg::PRIO_W'($urandom_range(0, 1))
                    : spq_pkg::PRIO_W'($urandom_range(0, 15));
      issue_command(cmd, prio, spq_pkg::ID_W'($urandom));
      sent++;
      seg_left--;
      burst_left--;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = spq_pkg::CMD_INSERT;
    in_priority_req = '0;
    in_entry_id     = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    shadow_count    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_remove();
    test_fill_and_overflow();
    test_stable_order();
    wait_drained();
    test_random_traffic(1700);

    wait_drained();
    // let the clock run on to catch any stray strobe
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue.sv
test/stable_priority_queue_test.sv
